FILE: design/hvd_pkg.sv
// Package: sizes, codes, table entry type, control structs and saturation helpers.
package hvd_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int MAX_CODE_BITS = 32;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_DECODE = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_MISS    = 2'd1,
		STS_FULL    = 2'd2,
		STS_BADCODE = 2'd3
	} status_t;

	typedef struct packed {
		logic [5:0]  len;
		logic [31:0] code;
		logic [31:0] first;
		logic [31:0] second;
	} entry_t;

	typedef struct packed {
		logic cap;
		logic scan_en;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic in_decode;
		logic scan_done;
	} dp_sts_t;

	function automatic logic signed [7:0] sat8(input logic signed [31:0] v);
		logic signed [7:0] r;
		if (v > 32'sd127) begin
			r = 8'sd127;
		end else if (v < -32'sd128) begin
			r = -8'sd128;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		logic signed [15:0] r;
		if (v > 32'sd32767) begin
			r = 16'sd32767;
		end else if (v < -32'sd32768) begin
			r = -16'sd32768;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

FILE: design/hvd_ifs.sv
// Channel interfaces: input item, result item and configuration write.
interface hvd_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [5:0]         code_length;
	logic [31:0]        codeword;
	logic signed [31:0] entry_first;
	logic signed [31:0] entry_second;
	logic [31:0]        current_word;
	logic [31:0]        next_word;
	logic [4:0]         bit_position;

	modport source (output valid, action, code_length, codeword, entry_first, entry_second,
		current_word, next_word, bit_position, input ready);
	modport sink (input valid, action, code_length, codeword, entry_first, entry_second,
		current_word, next_word, bit_position, output ready);
endinterface

interface hvd_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] first_value;
	logic signed [15:0] second_value;
	logic [4:0]         new_bit_position;
	logic               words_advanced;
	logic [1:0]         status;

	modport source (output valid, first_value, second_value, new_bit_position,
		words_advanced, status, input ready);
	modport sink (input valid, first_value, second_value, new_bit_position,
		words_advanced, status, output ready);
endinterface

interface hvd_cfg_if;
	logic valid;
	logic ready;
	logic pair_mode;

	modport source (output valid, pair_mode, input ready);
	modport sink (input valid, pair_mode, output ready);
endinterface

FILE: design/hvd_ctrl.sv
// Controller: accept / scan / deliver state machine and output valid flag.
module hvd_ctrl import hvd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_vld_q;
	logic   out_free;

	assign out_free  = !out_vld_q || out_ready;
	assign out_valid = out_vld_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = sts.in_decode ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/hvd_dp.sv
// Datapath: code table memory, entry scan and match, result formatting.
module hvd_dp import hvd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic               cfg_we,
	input  logic               cfg_pair_mode,
	input  logic [1:0]         action,
	input  logic [5:0]         code_length,
	input  logic [31:0]        codeword,
	input  logic signed [31:0] entry_first,
	input  logic signed [31:0] entry_second,
	input  logic [31:0]        current_word,
	input  logic [31:0]        next_word,
	input  logic [4:0]         bit_position,
	output logic signed [31:0] first_value,
	output logic signed [15:0] second_value,
	output logic [4:0]         new_bit_position,
	output logic               words_advanced,
	output logic [1:0]         status
);

	entry_t mem [TABLE_ENTRIES];

	logic               pair_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         act_q;
	logic [5:0]         len_q;
	logic [31:0]        cw_q;
	logic [31:0]        v1_q;
	logic [31:0]        v2_q;
	logic [4:0]         pos_q;
	logic [31:0]        str_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               rd_vld_q;
	entry_t             rd_entry_q;
	logic               found_q;
	logic [5:0]         hit_len_q;
	logic [31:0]        hit_first_q;
	logic [31:0]        hit_second_q;
	logic signed [31:0] first_q;
	logic signed [15:0] second_q;
	logic [4:0]         newpos_q;
	logic               adv_q;
	logic [1:0]         sts_q;

	logic [63:0]  win_shift;
	logic         rd_en;
	logic         match;
	logic [5:0]   cmp_sh;
	logic         bad_code;
	logic [1:0]   load_sts;
	logic         wr_en;
	entry_t       wr_entry;
	logic         is_load;
	logic         is_decode;
	logic         is_clear;
	logic signed [7:0]  sat_first;
	logic signed [15:0] sat_second;

	assign is_load   = (act_q == ACT_LOAD);
	assign is_decode = (act_q == ACT_DECODE);
	assign is_clear  = (act_q == ACT_CLEAR);

	assign win_shift = {current_word, next_word} << (5'd31 - bit_position);

	assign rd_en  = cmd.scan_en && (rd_idx_q < cnt_q);
	assign cmp_sh = 6'd32 - rd_entry_q.len;
	assign match  = rd_vld_q && ((str_q >> cmp_sh) == rd_entry_q.code);

	assign sts.in_decode = (action == ACT_DECODE);
	assign sts.scan_done = match || (!rd_vld_q && (rd_idx_q == cnt_q));

	assign bad_code = (len_q == 6'd0) || (len_q > 6'(MAX_CODE_BITS))
		|| (({32'd0, cw_q} >> len_q) != 64'd0);

	always_comb begin
		if (cnt_q >= CNT_W'(TABLE_ENTRIES)) begin
			load_sts = STS_FULL;
		end else if (bad_code) begin
			load_sts = STS_BADCODE;
		end else begin
			load_sts = STS_OK;
		end
	end

	assign wr_en    = cmd.out_load && is_load && (load_sts == STS_OK);
	assign wr_entry = '{len: len_q, code: cw_q, first: v1_q, second: v2_q};

	assign sat_first  = sat8(hit_first_q);
	assign sat_second = sat16(hit_second_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IDX_W-1:0]] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q   <= 1'b0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			rd_vld_q <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				pair_q <= cfg_pair_mode;
			end
			if (cmd.cap) begin
				rd_idx_q <= '0;
				rd_vld_q <= 1'b0;
				found_q  <= 1'b0;
			end else if (cmd.scan_en) begin
				rd_vld_q <= rd_en;
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (match) begin
					found_q <= 1'b1;
				end
			end
			if (wr_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.out_load && is_clear) begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			act_q <= action;
			len_q <= code_length;
			cw_q  <= codeword;
			v1_q  <= entry_first;
			v2_q  <= entry_second;
			pos_q <= bit_position;
			str_q <= win_shift[63:32];
		end
		if (cmd.scan_en && match) begin
			hit_len_q    <= rd_entry_q.len;
			hit_first_q  <= rd_entry_q.first;
			hit_second_q <= rd_entry_q.second;
		end
		if (cmd.out_load) begin
			if (is_decode && found_q) begin
				newpos_q <= pos_q - hit_len_q[4:0];
				adv_q    <= ({1'b0, pos_q} < hit_len_q);
				if (pair_q) begin
					first_q  <= {{24{sat_first[7]}}, sat_first};
					second_q <= sat_second;
				end else begin
					first_q  <= hit_first_q;
					second_q <= '0;
				end
			end else begin
				first_q  <= '0;
				second_q <= '0;
				newpos_q <= pos_q;
				adv_q    <= 1'b0;
			end
			if (is_load) begin
				sts_q <= load_sts;
			end else if (is_decode && !found_q) begin
				sts_q <= STS_MISS;
			end else begin
				sts_q <= STS_OK;
			end
		end
	end

	assign first_value      = first_q;
	assign second_value     = second_q;
	assign new_bit_position = newpos_q;
	assign words_advanced   = adv_q;
	assign status           = sts_q;

endmodule

FILE: design/huffman_vlc_table_decoder_unit.sv
// Top level: prefix code table decoder, controller plus datapath.
//
//  channel  dir  beat contents
//  item     in   action, code_length, codeword, entry_first/second, words, bit_position
//  result   out  first_value, second_value, new_bit_position, words_advanced, status
//  cfg      in   pair_mode, always ready
//
// Load, clear and idle actions skip the table scan. Decode time is set by the table
// scan (one registered memory read per entry, first hit stops).
// Reset: entry count zero, pair_mode 0; table contents undefined, no clearing pass.
// A finished result waits in the output register; the next item is taken meanwhile
// and only its delivery waits for result.ready.
module huffman_vlc_table_decoder_unit import hvd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	hvd_item_if.sink   item,
	hvd_result_if.source result,
	hvd_cfg_if.sink    cfg
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg.ready = 1'b1;

	hvd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hvd_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg.valid),
		.cfg_pair_mode    (cfg.pair_mode),
		.action           (item.action),
		.code_length      (item.code_length),
		.codeword         (item.codeword),
		.entry_first      (item.entry_first),
		.entry_second     (item.entry_second),
		.current_word     (item.current_word),
		.next_word        (item.next_word),
		.bit_position     (item.bit_position),
		.first_value      (result.first_value),
		.second_value     (result.second_value),
		.new_bit_position (result.new_bit_position),
		.words_advanced   (result.words_advanced),
		.status           (result.status)
	);

endmodule

FILE: test/tb_top.sv
// Testbench for the prefix code table decoder: predictor, stimulus tasks and result checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hvd_pkg::*;

	localparam logic [1:0] ACT_IDLE = 2'd3;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic [1:0]  action;
		logic [5:0]  len;
		logic [31:0] codeword;
		logic [31:0] first;
		logic [31:0] second;
		logic [31:0] cur_word;
		logic [31:0] nxt_word;
		logic [4:0]  pos;
	} vlc_item_t;

	typedef struct {
		logic signed [31:0] first;
		logic signed [15:0] second;
		logic [4:0]         new_pos;
		logic               adv;
		status_t            status;
	} vlc_result_t;

	logic clk = 1'b0;
	logic arst_n;

	hvd_item_if   item_bus();
	hvd_result_if res_bus();
	hvd_cfg_if    cfg_bus();

	huffman_vlc_table_decoder_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (res_bus),
		.cfg    (cfg_bus)
	);

	always #2 clk = ~clk;

	// code table shadow
	logic [31:0] tbl_code   [TABLE_ENTRIES];
	int          tbl_len    [TABLE_ENTRIES];
	logic [31:0] tbl_first  [TABLE_ENTRIES];
	logic [31:0] tbl_second [TABLE_ENTRIES];
	int          tbl_count = 0;
	bit          mode_pair = 1'b0;

	vlc_result_t pending_results[$];
	vlc_result_t want;
	int          errors = 0;
	int          items_sent = 0;
	bit          idle_on = 1'b0;
	bit          item_driving = 1'b0;
	int          rx_hold_cycles = 0;

	function automatic logic [31:0] clamp_signed(input logic [31:0] v, input int bits);
		longint hi;
		longint lo;
		longint x;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		x = longint'($signed(v));
		if (x > hi) begin
			x = hi;
		end else if (x < lo) begin
			x = lo;
		end
		return x[31:0];
	endfunction

	function automatic vlc_result_t predict_vlc_result(input vlc_item_t it);
		vlc_result_t r;
		logic [63:0] window;
		logic [63:0] bits;
		int          l;
		int          p;
		bit          hit;
		r.first = '0;
		r.second = '0;
		r.new_pos = it.pos;
		r.adv = 1'b0;
		r.status = STS_OK;
		p = it.pos;
		if (it.action == ACT_LOAD) begin
			if (tbl_count >= TABLE_ENTRIES) begin
				r.status = STS_FULL;
			end else if (it.len == 0 || it.len > MAX_CODE_BITS ||
				(({32'd0, it.codeword} >> it.len) != 64'd0)) begin
				r.status = STS_BADCODE;
			end else begin
				tbl_code[tbl_count] = it.codeword;
				tbl_len[tbl_count] = it.len;
				tbl_first[tbl_count] = it.first;
				tbl_second[tbl_count] = it.second;
				tbl_count++;
			end
		end else if (it.action == ACT_DECODE) begin
			window = {it.cur_word, it.nxt_word};
			hit = 1'b0;
			for (int i = 0; i < tbl_count && !hit; i++) begin
				l = tbl_len[i];
				bits = (window >> (33 + p - l)) & ((64'd1 << l) - 64'd1);
				if (bits == {32'd0, tbl_code[i]}) begin
					hit = 1'b1;
					if (p >= l) begin
						r.new_pos = 5'(p - l);
						r.adv = 1'b0;
					end else begin
						r.new_pos = 5'(p + 32 - l);
						r.adv = 1'b1;
					end
					if (mode_pair) begin
						r.first = clamp_signed(tbl_first[i], 8);
						r.second = 16'(clamp_signed(tbl_second[i], 16));
					end else begin
						r.first = tbl_first[i];
						r.second = '0;
					end
				end
			end
			if (!hit) begin
				r.status = STS_MISS;
			end
		end else if (it.action == ACT_CLEAR) begin
			tbl_count = 0;
		end
		return r;
	endfunction

	function automatic vlc_item_t noise_item();
		vlc_item_t it;
		it.action = 2'($urandom_range(0, 3));
		it.len = 6'($urandom_range(0, 63));
		it.codeword = $urandom;
		it.first = $urandom;
		it.second = $urandom;
		it.cur_word = $urandom;
		it.nxt_word = $urandom;
		it.pos = 5'($urandom_range(0, 31));
		return it;
	endfunction

	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		case ($urandom_range(0, 11))
			0: v = 32'd127;
			1: v = 32'd128;
			2: v = -32'sd128;
			3: v = -32'sd129;
			4: v = 32'd32767;
			5: v = 32'd32768;
			6: v = -32'sd32768;
			7: v = -32'sd32769;
			8: v = 32'($urandom_range(0, 512)) - 32'd256;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic send_item(input vlc_item_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			if (item_driving) begin
				item_bus.valid <= 1'b0;
			end
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		item_bus.valid        <= 1'b1;
		item_bus.action       <= it.action;
		item_bus.code_length  <= it.len;
		item_bus.codeword     <= it.codeword;
		item_bus.entry_first  <= it.first;
		item_bus.entry_second <= it.second;
		item_bus.current_word <= it.cur_word;
		item_bus.next_word    <= it.nxt_word;
		item_bus.bit_position <= it.pos;
		item_driving = 1'b1;
		do @(posedge clk); while (!item_bus.ready);
		pending_results.insert(pending_results.size(), predict_vlc_result(it));
		if (it.action != ACT_IDLE) begin
			items_sent++;
		end
	endtask

	task automatic send_load(input int len, input logic [31:0] cw, input logic [31:0] v1,
		input logic [31:0] v2);
		vlc_item_t it;
		it = noise_item();
		it.action = ACT_LOAD;
		it.len = 6'(len);
		it.codeword = cw;
		it.first = v1;
		it.second = v2;
		send_item(it);
	endtask

	task automatic send_decode(input logic [31:0] cw_cur, input logic [31:0] cw_nxt,
		input logic [4:0] pos);
		vlc_item_t it;
		it = noise_item();
		it.action = ACT_DECODE;
		it.cur_word = cw_cur;
		it.nxt_word = cw_nxt;
		it.pos = pos;
		send_item(it);
	endtask

	task automatic send_action(input logic [1:0] act);
		vlc_item_t it;
		it = noise_item();
		it.action = act;
		send_item(it);
	endtask

	// place a stored code, if the table holds one, at a random position of a random stream
	task automatic send_hit_decode();
		int idx;
		int l;
		int p;
		logic [63:0] w;
		p = $urandom_range(0, 31);
		w = {$urandom, $urandom};
		if (tbl_count > 0) begin
			idx = $urandom_range(0, tbl_count - 1);
			l = tbl_len[idx];
			for (int j = 0; j < l; j++) begin
				w[33 + p - l + j] = tbl_code[idx][j];
			end
		end
		send_decode(w[63:32], w[31:0], p[4:0]);
	endtask

	task automatic load_random_entry();
		int r;
		int len;
		logic [31:0] cw;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			len = $urandom_range(1, 8);
		end else if (r < 9) begin
			len = $urandom_range(9, 24);
		end else begin
			len = $urandom_range(25, 32);
		end
		cw = $urandom;
		if ($urandom_range(0, 9) != 0 && len < 32) begin
			cw = cw & ((32'd1 << len) - 32'd1);
		end
		send_load(len, cw, rand_value(), rand_value());
	endtask

	task automatic pause_until_drained();
		if (item_driving) begin
			item_bus.valid <= 1'b0;
			item_driving = 1'b0;
		end
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_pair_mode(input bit m);
		cfg_bus.valid     <= 1'b1;
		cfg_bus.pair_mode <= m;
		do @(posedge clk); while (!cfg_bus.ready);
		mode_pair = m;
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		idle_on = 1'b1;
		send_decode($urandom, $urandom, 5'd31);
		send_action(ACT_CLEAR);
		send_load(1, 32'h1, 32'h7fff_ffff, 32'h8000_0000);
		send_load(32, 32'h0, 32'h8000_0000, 32'h7fff_ffff);
		send_load(3, 32'h2, 32'hffff_ffff, -32'sd32769);
		send_load(3, 32'h2, 32'd5, 32'd6);
		send_load(0, 32'h0, $urandom, $urandom);
		send_load(33, 32'h1, $urandom, $urandom);
		send_load(63, 32'hffff_ffff, $urandom, $urandom);
		send_load(4, 32'h10, $urandom, $urandom);
		send_action(ACT_IDLE);
		send_decode(32'h8000_0000, $urandom, 5'd31);
		send_decode(32'h0000_0001, $urandom, 5'd0);
		send_decode(32'h0000_0001, 32'h7fff_ffff, 5'd1);
		send_decode(32'h0, 32'h0, 5'd17);
		send_decode(32'h6000_0000, $urandom, 5'd31);
		send_decode(32'h0, 32'h0, 5'd31);
	endtask

	task automatic test_pair_mode();
		pause_until_drained();
		set_pair_mode(1'b1);
		send_decode(32'h8000_0000, $urandom, 5'd31);
		send_decode(32'h0, 32'h0, 5'd17);
		send_decode(32'h0000_0001, 32'h7fff_ffff, 5'd1);
		send_load(5, 32'h7, 32'd127, -32'sd32768);
		send_load(5, 32'h6, -32'sd128, 32'd32767);
		send_decode(32'h3800_0000, $urandom, 5'd31);
		send_decode(32'h3000_0000, $urandom, 5'd31);
		pause_until_drained();
		set_pair_mode(1'b0);
		send_decode(32'h8000_0000, $urandom, 5'd31);
		send_action(ACT_CLEAR);
		send_decode(32'h8000_0000, $urandom, 5'd31);
		pause_until_drained();
	endtask

	task automatic test_output_stall();
		idle_on = 1'b0;
		repeat (3) load_random_entry();
		rx_hold_cycles = 200;
		repeat (12) send_hit_decode();
		pause_until_drained();
	endtask

	task automatic test_random(input int target);
		int kind;
		int n;
		while (items_sent < target) begin
			idle_on = ($urandom_range(0, 4) != 0);
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				if (tbl_count > 48 || $urandom_range(0, 2) == 0) begin
					send_action(ACT_CLEAR);
				end
				n = ($urandom_range(0, 14) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 12);
				repeat (n) load_random_entry();
				repeat ($urandom_range(4, 20)) begin
					if ($urandom_range(0, 6) != 0) begin
						send_hit_decode();
					end else begin
						send_decode($urandom, $urandom, 5'($urandom_range(0, 31)));
					end
				end
			end else if (kind <= 7) begin
				repeat ($urandom_range(2, 10)) send_item(noise_item());
			end else if (kind == 8) begin
				pause_until_drained();
				set_pair_mode(1'($urandom_range(0, 1)));
			end else begin
				send_action(ACT_CLEAR);
				repeat ($urandom_range(1, 4)) send_hit_decode();
			end
		end
	endtask

	task automatic test_no_idle(input int count);
		idle_on = 1'b0;
		send_action(ACT_CLEAR);
		repeat (10) load_random_entry();
		repeat (count) begin
			if ($urandom_range(0, 5) == 0) begin
				load_random_entry();
			end else begin
				send_hit_decode();
			end
		end
	endtask

	// result receiver: random stalls plus an occasional long hold
	initial begin
		int n;
		res_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				res_bus.ready <= 1'b0;
				n = rx_hold_cycles;
				rx_hold_cycles = 0;
				repeat (n - 1) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				res_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(posedge clk);
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors < 50) begin
					$display("%0t unexpected beat: first=%h second=%h pos=%0d adv=%0d status=%0d",
						$time, res_bus.first_value, res_bus.second_value,
						res_bus.new_bit_position, res_bus.words_advanced, res_bus.status);
				end
			end else begin
				want = pending_results.pop_front();
				if (res_bus.first_value !== want.first || res_bus.second_value !== want.second ||
					res_bus.new_bit_position !== want.new_pos ||
					res_bus.words_advanced !== want.adv || res_bus.status !== want.status) begin
					errors++;
					if (errors < 50) begin
						$display("%0t mismatch: exp first=%h second=%h pos=%0d adv=%0d status=%0d",
							$time, want.first, want.second, want.new_pos, want.adv, want.status);
						$display("%0t          got first=%h second=%h pos=%0d adv=%0d status=%0d",
							$time, res_bus.first_value, res_bus.second_value,
							res_bus.new_bit_position, res_bus.words_advanced, res_bus.status);
					end
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.action = ACT_LOAD;
		item_bus.code_length = '0;
		item_bus.codeword = '0;
		item_bus.entry_first = '0;
		item_bus.entry_second = '0;
		item_bus.current_word = '0;
		item_bus.next_word = '0;
		item_bus.bit_position = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.pair_mode = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pair_mode();
		test_output_stall();
		test_random(1600);
		test_no_idle(200);
		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
